>>> rtl/md5_byte_stream_hasher_macros.svh
// Assertion helpers for the MD5 hasher.
`ifndef MD5_BYTE_STREAM_HASHER_MACROS_SVH
`define MD5_BYTE_STREAM_HASHER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define MD5_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define MD5_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/md5h_pkg.sv
package md5h_pkg;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
  localparam logic [5:0] LEN_OFFSET    = 6'd56;
  localparam logic [5:0] LAST_SLOT     = 6'd63;
  localparam logic [5:0] LAST_STEP     = 6'd63;
  localparam logic [1:0] LAST_WORD_IDX = 2'd3;

  localparam logic [31:0] STEP_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_FOLD,
    ST_MARK,
    ST_ZERO,
    ST_LEN,
    ST_OUT
  } md5_state_t;

  function automatic logic [4:0] rot_amount(input logic [5:0] step);
    logic [4:0] s;
    case ({step[5:4], step[1:0]})
      4'd0:    s = 5'd7;
      4'd1:    s = 5'd12;
      4'd2:    s = 5'd17;
      4'd3:    s = 5'd22;
      4'd4:    s = 5'd5;
      4'd5:    s = 5'd9;
      4'd6:    s = 5'd14;
      4'd7:    s = 5'd20;
      4'd8:    s = 5'd4;
      4'd9:    s = 5'd11;
      4'd10:   s = 5'd16;
      4'd11:   s = 5'd23;
      4'd12:   s = 5'd6;
      4'd13:   s = 5'd10;
      4'd14:   s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Word of the block consumed at a given step.
  function automatic logic [3:0] msg_index(input logic [5:0] step);
    logic [3:0] lo;
    logic [3:0] g;
    lo = step[3:0];
    case (step[5:4])
      2'd0:    g = lo;
      2'd1:    g = 4'(lo * 4'd5 + 4'd1);
      2'd2:    g = 4'(lo * 4'd3 + 4'd5);
      default: g = 4'(lo * 4'd7);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] t;
    t = {v, v} << s;
    return t[63:32];
  endfunction

endpackage

>>> rtl/md5_byte_stream_hasher.sv
// A byte request is taken while idle; a byte that fills the 64-byte block starts a compression
// (load, 64 rounds on the shared round unit, chain update) that ends before the next request.
// End of message: pad and length bytes go in one per cycle, paused while a full block is
// compressed, with one slot at offset 56 that writes nothing; a compression runs for each of the
// one or two closing blocks, then four digest words follow, one per cycle while m_tready is high.
// Reset (rst, synchronous, active high) restores the chaining words, clears the bit count.
`include "md5_byte_stream_hasher_macros.svh"

module md5_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] byte_valid
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [1:0]  m_tuser,   // [1:0] word_index
  output logic        m_tlast
);
  import md5h_pkg::*;

  md5_state_t  state, state_next;
  md5_state_t  ret_state, ret_next;

  logic [31:0] chain [4];
  logic [63:0] bit_count;
  logic [5:0]  fill;
  logic [5:0]  rnd;
  logic [1:0]  out_idx;
  logic [31:0] a, b, c, d;

  logic [31:0] buf_mem [16];
  logic [31:0] mem_q;

  logic        in_acc, out_acc;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic        byte_in;
  logic [3:0]  raddr;
  logic [5:0]  rd_step;
  logic [31:0] f_val, sum, b_new;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  // Next state
  always_comb begin
    state_next = state;
    ret_next   = ret_state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_tuser[0] && fill == LAST_SLOT) begin
            state_next = ST_LOAD;
            ret_next   = s_tlast ? ST_MARK : ST_IDLE;
          end else if (s_tlast) begin
            state_next = ST_MARK;
          end
        end
      end
      ST_LOAD: state_next = ST_RUN;
      ST_RUN:  if (rnd == LAST_STEP) state_next = ST_FOLD;
      ST_FOLD: state_next = ret_state;
      ST_MARK: begin
        if (fill == LAST_SLOT) begin
          state_next = ST_LOAD;
          ret_next   = ST_ZERO;
        end else begin
          state_next = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (fill == LEN_OFFSET) begin
          state_next = ST_LEN;
        end else if (fill == LAST_SLOT) begin
          state_next = ST_LOAD;
          ret_next   = ST_ZERO;
        end
      end
      ST_LEN: begin
        if (fill == LAST_SLOT) begin
          state_next = ST_LOAD;
          ret_next   = ST_OUT;
        end
      end
      ST_OUT:  if (out_acc && out_idx == LAST_WORD_IDX) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    wr_en   = 1'b0;
    wr_byte = s_tdata;
    byte_in = 1'b0;
    rd_step = '0;
    case (state)
      ST_IDLE: begin
        wr_en   = in_acc && s_tuser[0];
        byte_in = wr_en;
      end
      ST_RUN:  rd_step = 6'(rnd + 6'd1);
      ST_MARK: begin
        wr_en   = 1'b1;
        wr_byte = PAD_MARK_BYTE;
      end
      ST_ZERO: begin
        wr_en   = (fill != LEN_OFFSET);
        wr_byte = '0;
      end
      ST_LEN: begin
        wr_en   = 1'b1;
        wr_byte = bit_count[{fill[2:0], 3'b000} +: 8];
      end
      default: ;
    endcase
    raddr = msg_index(rd_step);
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = chain[out_idx];
  assign m_tuser  = out_idx;
  assign m_tlast  = (out_idx == LAST_WORD_IDX);

  // Round unit
  always_comb begin
    case (rnd[5:4])
      2'd0:    f_val = d ^ (b & (c ^ d));
      2'd1:    f_val = c ^ (d & (b ^ c));
      2'd2:    f_val = b ^ c ^ d;
      default: f_val = c ^ (b | ~d);
    endcase
    sum   = a + f_val + STEP_K[rnd] + mem_q;
    b_new = b + rotl32(sum, rot_amount(rnd));
  end

  // Block buffer, byte-lane writes, registered word read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_mem[fill[5:2]][{fill[1:0], 3'b000} +: 8] <= wr_byte;
    end
    mem_q <= buf_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_IDLE;
      chain[0]  <= INIT_A;
      chain[1]  <= INIT_B;
      chain[2]  <= INIT_C;
      chain[3]  <= INIT_D;
      bit_count <= '0;
      fill      <= '0;
      rnd       <= '0;
      out_idx   <= '0;
    end else begin
      state     <= state_next;
      ret_state <= ret_next;
      if (wr_en) fill <= 6'(fill + 6'd1);
      if (byte_in) bit_count <= bit_count + 64'd8;
      case (state)
        ST_LOAD: begin
          rnd <= '0;
        end
        ST_RUN: begin
          rnd <= 6'(rnd + 6'd1);
        end
        ST_FOLD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
        end
        ST_OUT: begin
          if (out_acc) begin
            out_idx <= 2'(out_idx + 2'd1);
            // restart for the next message after word D
            if (out_idx == LAST_WORD_IDX) begin
              chain[0]  <= INIT_A;
              chain[1]  <= INIT_B;
              chain[2]  <= INIT_C;
              chain[3]  <= INIT_D;
              bit_count <= '0;
              fill      <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
    end else if (state == ST_RUN) begin
      a <= d;
      d <= c;
      c <= b;
      b <= b_new;
    end
  end

  `MD5_ASSERT_NOW(a_no_overlap, m_tvalid, !s_tready, "request taken while digest pending")
  `MD5_ASSERT_NOW(a_fill_sync, state == ST_IDLE, fill == bit_count[8:3],
                  "buffer fill out of step with bit count")
  `MD5_ASSERT_NOW(a_len_slot, state == ST_LEN, fill[5:3] == 3'b111,
                  "length bytes outside the block tail")
  `MD5_ASSERT_NEXT(a_run_end, state == ST_RUN && rnd == LAST_STEP, state == ST_FOLD,
                   "compression did not end after the last step")
  `MD5_ASSERT_NEXT(a_restart, out_acc && m_tlast, bit_count == '0 && fill == '0,
                   "no restart after the last digest word")

endmodule
